@@ design/bba_pkg.sv @@
// Shared types, constants and a helper function of the bitmap block allocator.
`default_nettype none
package bba_pkg;

  // Map geometry.
  localparam int MapWords  = 32;
  localparam int WordBits  = 32;
  localparam int AddrW     = $clog2(MapWords);
  localparam int BitW      = $clog2(WordBits);
  localparam int ActiveW   = $clog2(MapWords + 1);

  // Field widths.
  localparam int CmdW      = 2;
  localparam int IndexW    = 10;
  localparam int OffsetW   = 26;
  localparam int CountW    = 11;
  localparam int BytesW    = 17;
  localparam int CfgIdxW   = 2;

  // Reset values of the configuration registers.
  localparam logic [BytesW-1:0]  BytesReset  = BytesW'(16);
  localparam logic [ActiveW-1:0] ActiveReset = ActiveW'(MapWords);

  typedef enum logic [CmdW-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_BAD  = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BLOCK_BYTES  = 2'd0,
    CFG_ACTIVE_WORDS = 2'd1
  } cfg_idx_e;

  // Access request from the control logic to the bitmap store.
  typedef struct packed {
    logic                rd_en;
    logic [AddrW-1:0]    rd_addr;
    logic                wr_en;
    logic [AddrW-1:0]    wr_addr;
    logic [WordBits-1:0] wr_data;
    logic                clear;
  } map_req_t;

  // Position of the lowest set bit of a word; zero for an empty word.
  function automatic logic [BitW-1:0] lowest_set(input logic [WordBits-1:0] word);
    logic [BitW-1:0] pos;
    logic            found;
    pos   = '0;
    found = 1'b0;
    for (int i = 0; i < WordBits; i++) begin
      if (!found && word[i]) begin
        pos   = BitW'(i);
        found = 1'b1;
      end
    end
    return pos;
  endfunction

endpackage
`default_nettype wire

@@ design/bba_map.sv @@
// Bitmap store: one word memory with per-word valid bits that stand for the refill value.
`default_nettype none
module bba_map (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire bba_pkg::map_req_t                 req_i,
  input  wire logic [bba_pkg::ActiveW-1:0]       active_words_i,
  output logic      [bba_pkg::WordBits-1:0]      rd_word_o
);

  logic [bba_pkg::WordBits-1:0] mem [bba_pkg::MapWords];
  logic [bba_pkg::MapWords-1:0] vld_q;
  logic [bba_pkg::WordBits-1:0] rd_data_q;
  logic [bba_pkg::AddrW-1:0]    rd_addr_q;
  logic                         rd_vld_q;

  // Word memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  // Valid bits: a word never written since the last refill reads as its fill value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rd_addr_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (req_i.clear) begin
        vld_q <= '0;
      end else if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_addr_q <= req_i.rd_addr;
        rd_vld_q  <= vld_q[req_i.rd_addr];
      end
    end
  end

  // Words in use refill to all ones, the rest to zero.
  always_comb begin
    if (rd_vld_q) begin
      rd_word_o = rd_data_q;
    end else if (bba_pkg::ActiveW'(rd_addr_q) < active_words_i) begin
      rd_word_o = '1;
    end else begin
      rd_word_o = '0;
    end
  end

endmodule
`default_nettype wire

@@ design/bitmap_block_allocator.sv @@
// Top level of the bitmap block allocator: command sequencer, counters and result register.
//
//  Channel  Direction  Handshake              Payload
//  in       sink       in_valid_i/in_ready_o  cmd_i, block_index_i
//  out      source     out_valid_o/out_ready_i status_o, alloc_index_o, byte_offset_o,
//                                             free_count_o
//  cfg      sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One command at a time. Clear, unused commands, a full pool and an out-of-range free go
// straight to the done state; a free passes through the bitmap read-modify-write state; an
// alloc scans one word per cycle from the memory, then forms the byte offset in a multiply state.
// After reset the map reads as all free through per-word valid bits; there is no clearing pass.
// A result that is not taken holds the sequencer in its final state; the next command is
// accepted once the result register has been loaded.
`default_nettype none
module bitmap_block_allocator (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Command channel.
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [bba_pkg::CmdW-1:0]          cmd_i,
  input  wire logic [bba_pkg::IndexW-1:0]        block_index_i,
  // Result channel.
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic      [1:0]                        status_o,
  output logic      [bba_pkg::IndexW-1:0]        alloc_index_o,
  output logic      [bba_pkg::OffsetW-1:0]       byte_offset_o,
  output logic      [bba_pkg::CountW-1:0]        free_count_o,
  // Configuration channel.
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [bba_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [bba_pkg::BytesW-1:0]        cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FREE,
    S_MUL,
    S_DONE
  } state_e;

  localparam int ProdW = bba_pkg::IndexW + bba_pkg::BytesW;

  state_e                             state_q;
  logic [bba_pkg::BytesW-1:0]         block_bytes_q;
  logic [bba_pkg::ActiveW-1:0]        active_q;
  logic [bba_pkg::AddrW-1:0]          cursor_q;
  logic [bba_pkg::CountW-1:0]         free_total_q;
  logic [bba_pkg::AddrW-1:0]          scan_w_q;
  logic [bba_pkg::IndexW-1:0]         blk_q;
  logic [bba_pkg::IndexW-1:0]         gidx_q;
  logic [bba_pkg::OffsetW-1:0]        off_q;
  bba_pkg::status_e                   stat_q;
  logic                               out_valid_q;
  logic [1:0]                         out_status_q;
  logic [bba_pkg::IndexW-1:0]         out_index_q;
  logic [bba_pkg::OffsetW-1:0]        out_offset_q;
  logic [bba_pkg::CountW-1:0]         out_count_q;

  bba_pkg::map_req_t                  map_req;
  logic [bba_pkg::WordBits-1:0]       map_word;
  logic                               in_fire;
  logic                               cfg_fire;
  logic [bba_pkg::AddrW-1:0]          start_w;
  logic [bba_pkg::AddrW-1:0]          next_w;
  logic [bba_pkg::BitW-1:0]           low_bit;
  logic                               word_nz;
  logic                               in_range;
  logic                               blk_set;
  logic [ProdW-1:0]                   prod;
  logic [bba_pkg::ActiveW-1:0]        cfg_active;
  logic                               load_out;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i & in_ready_o;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;

  // Scan helpers: start word, wrapped next word, lowest free bit.
  assign start_w  = (bba_pkg::ActiveW'(cursor_q) >= active_q) ? '0 : cursor_q;
  assign next_w   = (bba_pkg::ActiveW'(scan_w_q) + bba_pkg::ActiveW'(1) >= active_q)
                    ? '0 : scan_w_q + bba_pkg::AddrW'(1);
  assign low_bit  = bba_pkg::lowest_set(map_word);
  assign word_nz  = |map_word;
  assign in_range = (bba_pkg::ActiveW'(block_index_i[bba_pkg::IndexW-1:bba_pkg::BitW])
                     < active_q);
  assign blk_set  = map_word[blk_q[bba_pkg::BitW-1:0]];
  assign prod     = ProdW'(gidx_q) * ProdW'(block_bytes_q);
  assign load_out = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // Clamp a written pool size to one through the map depth.
  always_comb begin
    if (cfg_data_i[bba_pkg::ActiveW-1:0] == '0) begin
      cfg_active = bba_pkg::ActiveW'(1);
    end else if (cfg_data_i[bba_pkg::ActiveW-1:0] > bba_pkg::ActiveW'(bba_pkg::MapWords)) begin
      cfg_active = bba_pkg::ActiveW'(bba_pkg::MapWords);
    end else begin
      cfg_active = cfg_data_i[bba_pkg::ActiveW-1:0];
    end
  end

  // Bitmap accesses issued by the sequencer.
  always_comb begin
    map_req = '0;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (cmd_i == bba_pkg::CMD_ALLOC && free_total_q != '0) begin
            map_req.rd_en   = 1'b1;
            map_req.rd_addr = start_w;
          end else if (cmd_i == bba_pkg::CMD_FREE && in_range) begin
            map_req.rd_en   = 1'b1;
            map_req.rd_addr = block_index_i[bba_pkg::IndexW-1:bba_pkg::BitW];
          end
          map_req.clear = (cmd_i == bba_pkg::CMD_CLEAR);
        end
      end
      S_SCAN: begin
        if (word_nz) begin
          map_req.wr_en   = 1'b1;
          map_req.wr_addr = scan_w_q;
          map_req.wr_data = map_word & ~(bba_pkg::WordBits'(1) << low_bit);
        end else begin
          map_req.rd_en   = 1'b1;
          map_req.rd_addr = next_w;
        end
      end
      S_FREE: begin
        if (!blk_set) begin
          map_req.wr_en   = 1'b1;
          map_req.wr_addr = blk_q[bba_pkg::IndexW-1:bba_pkg::BitW];
          map_req.wr_data = map_word | (bba_pkg::WordBits'(1) << blk_q[bba_pkg::BitW-1:0]);
        end
      end
      default: begin
      end
    endcase
    if (cfg_fire && cfg_index_i == bba_pkg::CFG_ACTIVE_WORDS) begin
      map_req.clear = 1'b1;
    end
  end

  bba_map u_map (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (map_req),
    .active_words_i (active_q),
    .rd_word_o      (map_word)
  );

  // Sequencer, counters, configuration registers and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      block_bytes_q <= bba_pkg::BytesReset;
      active_q      <= bba_pkg::ActiveReset;
      cursor_q      <= '0;
      free_total_q  <= bba_pkg::CountW'(bba_pkg::MapWords * bba_pkg::WordBits);
      scan_w_q      <= '0;
      blk_q         <= '0;
      gidx_q        <= '0;
      off_q         <= '0;
      stat_q        <= bba_pkg::STAT_OK;
      out_valid_q   <= 1'b0;
      out_status_q  <= '0;
      out_index_q   <= '0;
      out_offset_q  <= '0;
      out_count_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            blk_q  <= block_index_i;
            gidx_q <= '0;
            off_q  <= '0;
            stat_q <= bba_pkg::STAT_OK;
            case (cmd_i)
              bba_pkg::CMD_ALLOC: begin
                if (free_total_q == '0) begin
                  stat_q  <= bba_pkg::STAT_FULL;
                  state_q <= S_DONE;
                end else begin
                  scan_w_q <= start_w;
                  state_q  <= S_SCAN;
                end
              end
              bba_pkg::CMD_FREE: begin
                if (in_range) begin
                  state_q <= S_FREE;
                end else begin
                  stat_q  <= bba_pkg::STAT_BAD;
                  state_q <= S_DONE;
                end
              end
              bba_pkg::CMD_CLEAR: begin
                cursor_q     <= '0;
                free_total_q <= bba_pkg::CountW'(active_q) * bba_pkg::CountW'(bba_pkg::WordBits);
                state_q      <= S_DONE;
              end
              default: begin
                stat_q  <= bba_pkg::STAT_BAD;
                state_q <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (word_nz) begin
            free_total_q <= free_total_q - bba_pkg::CountW'(1);
            cursor_q     <= scan_w_q;
            gidx_q       <= bba_pkg::IndexW'({scan_w_q, low_bit});
            state_q      <= S_MUL;
          end else begin
            scan_w_q <= next_w;
          end
        end
        S_FREE: begin
          if (blk_set) begin
            stat_q <= bba_pkg::STAT_BAD;
          end else begin
            free_total_q <= free_total_q + bba_pkg::CountW'(1);
          end
          state_q <= S_DONE;
        end
        S_MUL: begin
          off_q   <= prod[bba_pkg::OffsetW-1:0];
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (load_out) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase

      // Result register: load a finished beat, drop it once taken.
      if (load_out) begin
        out_valid_q  <= 1'b1;
        out_status_q <= stat_q;
        out_index_q  <= gidx_q;
        out_offset_q <= off_q;
        out_count_q  <= free_total_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      // Configuration writes; a new pool size refills the map.
      if (cfg_fire) begin
        case (cfg_index_i)
          bba_pkg::CFG_BLOCK_BYTES: begin
            block_bytes_q <= cfg_data_i;
          end
          bba_pkg::CFG_ACTIVE_WORDS: begin
            active_q     <= cfg_active;
            cursor_q     <= '0;
            free_total_q <= bba_pkg::CountW'(cfg_active) * bba_pkg::CountW'(bba_pkg::WordBits);
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign alloc_index_o = out_index_q;
  assign byte_offset_o = out_offset_q;
  assign free_count_o  = out_count_q;

endmodule
`default_nettype wire

@@ test/allocator_checker.sv @@
// Checker for the bitmap block allocator: tracks the pool, predicts every reply and compares.
`default_nettype none
module allocator_checker
  import bba_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_ready_i,
  input  wire logic [CmdW-1:0]     cmd_i,
  input  wire logic [IndexW-1:0]   block_index_i,
  input  wire logic                out_valid_i,
  input  wire logic                out_ready_i,
  input  wire logic [1:0]          status_i,
  input  wire logic [IndexW-1:0]   alloc_index_i,
  input  wire logic [OffsetW-1:0]  byte_offset_i,
  input  wire logic [CountW-1:0]   free_count_i,
  input  wire logic                cfg_valid_i,
  input  wire logic                cfg_ready_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [BytesW-1:0]   cfg_data_i,
  output int                       outstanding_o,
  output int                       errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // One reply of the allocator as the pool model sees it.
  typedef struct {
    status_e              status;
    logic [IndexW-1:0]    index;
    logic [OffsetW-1:0]   offset;
    logic [CountW-1:0]    count;
  } reply_t;

  // Shadow copy of the pool and its settings.
  logic [WordBits-1:0] free_words [MapWords];
  logic [AddrW-1:0]    cursor;
  logic [CountW-1:0]   free_blocks;
  logic [BytesW-1:0]   block_size;
  int unsigned         words_in_use;

  reply_t awaited_replies [$];
  int     mismatch_count = 0;

  // Refill the words in use, clear the rest and restart the scan at word zero.
  function automatic void refill_pool();
    for (int w = 0; w < MapWords; w++) begin
      free_words[w] = (w < words_in_use) ? '1 : '0;
    end
    cursor      = '0;
    free_blocks = CountW'(words_in_use * WordBits);
  endfunction

  // Apply one register write; the word count is clamped to 1..MapWords and clears the pool.
  function automatic void write_setting(logic [CfgIdxW-1:0] idx, logic [BytesW-1:0] data);
    int unsigned words;
    if (idx == CFG_BLOCK_BYTES) begin
      block_size = data;
    end else if (idx == CFG_ACTIVE_WORDS) begin
      words = data[5:0];
      if (words == 0) words = 1;
      if (words > MapWords) words = MapWords;
      words_in_use = words;
      refill_pool();
    end
  endfunction

  // Carry out one command on the shadow pool and return the reply it should produce.
  function automatic reply_t apply_command(logic [CmdW-1:0] cmd, logic [IndexW-1:0] blk);
    reply_t          res;
    int unsigned     w;
    int unsigned     b;
    int unsigned     grant;
    bit              found;
    logic [63:0]     product;
    res.status = STAT_OK;
    res.index  = '0;
    res.offset = '0;
    found      = 1'b0;
    grant      = 0;
    case (cmd)
      CMD_ALLOC: begin
        // Next-fit scan from the cursor word, wrapping at the words in use.
        if (free_blocks != 0) begin
          w = (cursor >= words_in_use) ? 0 : cursor;
          for (int n = 0; n < words_in_use && !found; n++) begin
            if (free_words[w] != '0) begin
              b = 0;
              while (!free_words[w][b]) b++;
              free_words[w][b] = 1'b0;
              free_blocks      = free_blocks - 1'b1;
              cursor           = AddrW'(w);
              grant            = w * WordBits + b;
              found            = 1'b1;
            end else begin
              w++;
              if (w >= words_in_use) w = 0;
            end
          end
        end
        if (found) begin
          product    = 64'(grant) * 64'(block_size);
          res.index  = IndexW'(grant);
          res.offset = product[OffsetW-1:0];
        end else begin
          res.status = STAT_FULL;
        end
      end
      CMD_FREE: begin
        // Out-of-range and double frees are refused and leave the pool alone.
        w = blk / WordBits;
        b = blk % WordBits;
        if (w >= words_in_use) begin
          res.status = STAT_BAD;
        end else if (free_words[w][b]) begin
          res.status = STAT_BAD;
        end else begin
          free_words[w][b] = 1'b1;
          free_blocks      = free_blocks + 1'b1;
        end
      end
      CMD_CLEAR: begin
        refill_pool();
      end
      default: begin
        res.status = STAT_BAD;
      end
    endcase
    res.count = free_blocks;
    return res;
  endfunction

  // Compare one field and count a mismatch.
  function automatic void check_field(string field, longint unsigned want, longint unsigned got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endfunction

  // Watch the three channels. Replies are checked before a new command is queued,
  // since a reply leaving at the same edge always belongs to an older command.
  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    if (!rst_ni) begin
      block_size   = BytesReset;
      words_in_use = MapWords;
      refill_pool();
      awaited_replies.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        write_setting(cfg_index_i, cfg_data_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (awaited_replies.size() == 0) begin
          $error("reply beat with no command outstanding: status %0d, index %0d",
                 status_i, alloc_index_i);
          mismatch_count++;
        end else begin
          want = awaited_replies.pop_front();
          check_field("status", want.status, status_i);
          check_field("alloc_index", want.index, alloc_index_i);
          check_field("byte_offset", want.offset, byte_offset_i);
          check_field("free_count", want.count, free_count_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        awaited_replies.push_back(apply_command(cmd_i, block_index_i));
      end
    end
    outstanding_o <= awaited_replies.size();
    errors_o      <= mismatch_count;
  end

endmodule
`default_nettype wire

@@ test/testbench.sv @@
// Top of the allocator testbench: clock, reset, command and register stimulus, and the verdict.
`default_nettype none
module testbench;
  import bba_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // The one command code that the package leaves unassigned.
  localparam logic [CmdW-1:0] CmdUnused = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CmdW-1:0]      cmd = CMD_ALLOC;
  logic [IndexW-1:0]    block_index = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           status;
  logic [IndexW-1:0]    alloc_index;
  logic [OffsetW-1:0]   byte_offset;
  logic [CountW-1:0]    free_count;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIdxW-1:0]   cfg_index = CFG_BLOCK_BYTES;
  logic [BytesW-1:0]    cfg_data = '0;
  int                   outstanding;
  int                   mismatches;

  int                   burst_left = 0;
  int                   ready_window = 0;
  int                   ready_mode = 0;

  bitmap_block_allocator i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .cmd_i         (cmd),
    .block_index_i (block_index),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .status_o      (status),
    .alloc_index_o (alloc_index),
    .byte_offset_o (byte_offset),
    .free_count_o  (free_count),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  allocator_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .cmd_i         (cmd),
    .block_index_i (block_index),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .status_i      (status),
    .alloc_index_i (alloc_index),
    .byte_offset_i (byte_offset),
    .free_count_i  (free_count),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .outstanding_o (outstanding),
    .errors_o      (mismatches)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The reply side stalls in windows: always ready, mostly ready, or mostly stalled.
  always @(posedge clk) begin
    if (ready_window == 0) begin
      ready_window <= $urandom_range(20, 80);
      ready_mode   <= $urandom_range(0, 2);
    end else begin
      ready_window <= ready_window - 1;
    end
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Send one command beat. Commands go out in bursts; between bursts valid drops for a
  // random gap, and about a third of the bursts follow the previous one with no gap.
  task automatic send_command(logic [CmdW-1:0] code, logic [IndexW-1:0] blk);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid    <= 1'b1;
    cmd         <= code;
    block_index <= blk;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop sending and wait until every reply has come back.
  task automatic wait_for_replies();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Write one register while the allocator is idle.
  task automatic write_register(cfg_idx_e idx, logic [BytesW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [IndexW-1:0] any_index();
    return IndexW'($urandom_range(0, (1 << IndexW) - 1));
  endfunction

  // Mixed traffic: allocs at the given share, frees up to idx_hi, a few clears and
  // unused codes.
  task automatic mixed_traffic(int count, int alloc_pct, int idx_hi);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < alloc_pct) send_command(CMD_ALLOC, any_index());
      else if (r < 94) send_command(CMD_FREE, IndexW'($urandom_range(0, idx_hi)));
      else if (r < 97) send_command(CMD_CLEAR, any_index());
      else send_command(CmdUnused, any_index());
    end
  endtask

  // Drive the cursor deep into the map: a long run of allocs with a few frees at indexes
  // up to the allocs issued so far, so that high indexes and wide offsets are granted.
  task automatic fill_pool(int allocs);
    int issued;
    int r;
    issued = 0;
    while (issued < allocs) begin
      r = $urandom_range(0, 99);
      if (r < 90) begin
        send_command(CMD_ALLOC, any_index());
        issued++;
      end else if (r < 98) begin
        send_command(CMD_FREE, IndexW'($urandom_range(0, issued)));
      end else begin
        send_command(CmdUnused, any_index());
      end
    end
  endtask

  // Run limit, far above the slowest correct run.
  initial begin
    #2ms;
    $display("testbench: errors");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    int words;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: grants, a double free, the last block, the unused code, a clear.
    send_command(CMD_ALLOC, '0);
    send_command(CMD_ALLOC, '0);
    send_command(CMD_FREE, 10'd0);
    send_command(CMD_FREE, 10'd0);
    send_command(CMD_FREE, 10'd1023);
    send_command(CmdUnused, 10'd1023);
    send_command(CMD_ALLOC, 10'd1023);
    send_command(CMD_CLEAR, '0);
    wait_for_replies();

    // A word count of zero means one word; a block size of zero gives zero offsets.
    write_register(CFG_ACTIVE_WORDS, '0);
    write_register(CFG_BLOCK_BYTES, '0);
    send_command(CMD_FREE, 10'd32);
    send_command(CMD_FREE, 10'd1023);
    send_command(CMD_ALLOC, '0);
    send_command(CMD_FREE, 10'd31);
    wait_for_replies();

    // A word count above the map size is clamped; the widest block size.
    write_register(CFG_ACTIVE_WORDS, BytesW'(63));
    write_register(CFG_BLOCK_BYTES, '1);
    send_command(CMD_ALLOC, '0);
    send_command(CMD_ALLOC, '0);
    send_command(CMD_CLEAR, '0);
    send_command(CMD_ALLOC, '0);
    wait_for_replies();

    // One word in use: the pool runs full over and over.
    write_register(CFG_ACTIVE_WORDS, BytesW'(1));
    write_register(CFG_BLOCK_BYTES, BytesW'($urandom_range(1, 65536)));
    mixed_traffic(50, 65, 40);
    wait_for_replies();

    // A random middle size with a random block size.
    words = $urandom_range(2, 31);
    write_register(CFG_ACTIVE_WORDS, BytesW'(words));
    write_register(CFG_BLOCK_BYTES, BytesW'($urandom_range(0, (1 << BytesW) - 1)));
    mixed_traffic(50, 55, (words * WordBits + 8 > 1023) ? 1023 : words * WordBits + 8);
    wait_for_replies();

    // Out-of-range count with stray upper data bits; frees anywhere in the index space.
    write_register(CFG_ACTIVE_WORDS, {(BytesW-6)'($urandom_range(0, 2047)), 6'd33});
    write_register(CFG_BLOCK_BYTES, BytesW'(65536));
    mixed_traffic(50, 50, 1023);
    wait_for_replies();

    // Deep fill with the widest block size on an eight-word pool.
    write_register(CFG_ACTIVE_WORDS, BytesW'(8));
    write_register(CFG_BLOCK_BYTES, '1);
    fill_pool(280);
    wait_for_replies();

    // A new block size alone keeps the nearly full map.
    write_register(CFG_BLOCK_BYTES, BytesW'(3));
    mixed_traffic(30, 50, 300);
    wait_for_replies();

    // Full map again with unit blocks.
    write_register(CFG_ACTIVE_WORDS, BytesW'(32));
    write_register(CFG_BLOCK_BYTES, BytesW'(1));
    mixed_traffic(50, 60, 1023);
    wait_for_replies();

    // Give any stray reply time to show up.
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ bitmap_block_allocator.f @@
design/bba_pkg.sv
design/bba_map.sv
design/bitmap_block_allocator.sv
test/allocator_checker.sv
test/testbench.sv
